### src/swt_pkg.sv
// Shared types and constants for the shell word tokenizer.
// Used by swt_cfg and shell_word_tokenizer_unit; depends on nothing.
package swt_pkg;

  // Input beat: mode 1 marks end of command
  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
  } swt_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;
    logic       done_res;
    logic [2:0] error_code;
    logic       last;
  } swt_out_t;

  // Escape lookup result
  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } swt_esc_t;

  // Configuration register indexes
  localparam logic [2:0] REG_HOME_LEN = 3'd0;
  localparam logic [2:0] REG_HOME0    = 3'd1;
  localparam logic [2:0] REG_HOME3    = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_ESC  = 3'd1;
  localparam logic [2:0] ERR_SPLICE   = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED = 3'd3;
  localparam logic [2:0] ERR_DANGLING = 3'd4;

  // Characters
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  // Map the character after a backslash (backslash itself handled apart)
  function automatic swt_esc_t esc_map(input logic [7:0] c);
    swt_esc_t r;
    r.ok = 1'b1;
    r.ch = c;
    unique case (c)
      CH_SPACE, CH_TILDE, CH_DQUOTE: r.ch = c;
      CH_LOW_N: r.ch = CH_NL;
      CH_LOW_R: r.ch = CH_CR;
      CH_LOW_T: r.ch = CH_TAB;
      default: begin
        r.ok = 1'b0;
        r.ch = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

### src/swt_cfg.sv
// Configuration registers: home path length and home path characters.
// Depends on swt_pkg. Gives the clamped length and one home byte by index.
module swt_cfg
  import swt_pkg::*;
#(
  parameter int HOME_MAX = 32,
  parameter int LW       = $clog2(HOME_MAX + 1),
  parameter int IW       = (HOME_MAX > 1) ? $clog2(HOME_MAX) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_wdata,
  input  logic [IW-1:0] rd_idx,
  output logic [LW-1:0] home_len_eff,
  output logic [7:0]    home_byte
);

  logic [5:0] home_len_r;
  logic [7:0] home_r [HOME_MAX];

  // Register writes; only the first HOME_MAX characters are kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_len_r <= 6'd0;
      for (int j = 0; j < HOME_MAX; j++) begin
        home_r[j] <= 8'h00;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_HOME_LEN) begin
        home_len_r <= cfg_wdata[5:0];
      end
      for (int j = 0; j < HOME_MAX; j++) begin
        if (cfg_index == REG_HOME0 + 3'(j >> 3) && cfg_index <= REG_HOME3) begin
          home_r[j] <= cfg_wdata[8*(j & 7) +: 8];
        end
      end
    end
  end

  // Lengths above HOME_MAX act as HOME_MAX
  assign home_len_eff = (home_len_r > 6'(HOME_MAX)) ? LW'(HOME_MAX) : LW'(home_len_r);
  assign home_byte    = home_r[rd_idx];

endmodule

### src/shell_word_tokenizer_unit.sv
// Shell word tokenizer: one character per beat in, token characters out.
// Depends on swt_pkg and swt_cfg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one character or an
//   end-of-command marker per beat. Result channel (out_valid / out_stall /
//   out_data) carries token characters, token-end marks and error codes; the
//   last result of each input beat has last set.
//   Configuration (cfg_we / cfg_index / cfg_wdata) holds the home length and
//   home characters; write it only while the block is idle.
//   A beat lands in the input register at acceptance, and its first result is
//   loaded into the output register once that register is free.
//   Throughput: one input beat per cycle while out_stall is low. An unquoted
//   tilde at a token start emits the home string one result per cycle (out_stall
//   low) and holds the input register till done; other beats give one result.
//   Reset clears the parser state, the configuration and the valid flags of both registers.
//   When the receiver stalls, the output register holds its result, the
//   input register fills and in_stall rises; no beat is lost.
module shell_word_tokenizer_unit
  import swt_pkg::*;
#(
  parameter int HOME_MAX = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  swt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output swt_out_t out_data,
  input  logic     cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int LW = $clog2(HOME_MAX + 1);
  localparam int IW = (HOME_MAX > 1) ? $clog2(HOME_MAX) : 1;

  // Input register, output register, expansion counter
  logic          inp_valid_r;
  swt_in_t       inp_r;
  logic          out_valid_r;
  swt_out_t      out_r;
  logic [LW-1:0] idx_r;

  // Parser state
  logic       in_quote_r,  in_quote_nxt;
  logic       esc_r,       esc_nxt;
  logic       tok_r,       tok_nxt;
  logic       qjc_r,       qjc_nxt;
  logic [2:0] sticky_r,    sticky_nxt;

  logic [LW-1:0] home_len_eff;
  logic [7:0]    home_byte;

  swt_cfg #(
    .HOME_MAX(HOME_MAX),
    .LW      (LW),
    .IW      (IW)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .rd_idx      (idx_r[IW-1:0]),
    .home_len_eff(home_len_eff),
    .home_byte   (home_byte)
  );

  // Result for the item in the input register
  swt_out_t res;
  swt_esc_t esc_res;
  logic     expand;
  logic [2:0] err_new;

  always_comb begin
    res          = '0;
    expand       = 1'b0;
    err_new      = sticky_r;
    in_quote_nxt = in_quote_r;
    esc_nxt      = esc_r;
    tok_nxt      = tok_r;
    qjc_nxt      = qjc_r;
    esc_res      = esc_map(inp_r.ch);

    if (inp_r.mode) begin
      // End of command: report open quote or escape, close token, clear
      res.done_res = 1'b1;
      if (sticky_r == ERR_NONE) begin
        priority if (in_quote_r) err_new = ERR_UNCLOSED;
        else if (esc_r)           err_new = ERR_DANGLING;
        else if (tok_r)           res.token_end = 1'b1;
      end
      in_quote_nxt = 1'b0;
      esc_nxt      = 1'b0;
      tok_nxt      = 1'b0;
      qjc_nxt      = 1'b0;
    end else begin
      qjc_nxt = 1'b0;
      priority if (sticky_r != ERR_NONE) begin
        // sticky error: quiet result
      end else if (qjc_r && inp_r.ch == CH_DQUOTE) begin
        err_new = ERR_SPLICE;
      end else if (inp_r.ch == CH_BSLASH) begin
        if (!esc_r) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt        = 1'b0;
          tok_nxt        = 1'b1;
          res.out_char   = CH_BSLASH;
          res.char_valid = 1'b1;
        end
      end else if (esc_r) begin
        if (esc_res.ok) begin
          esc_nxt        = 1'b0;
          tok_nxt        = 1'b1;
          res.out_char   = esc_res.ch;
          res.char_valid = 1'b1;
        end else begin
          err_new = ERR_BAD_ESC;
        end
      end else if (inp_r.ch == CH_TILDE && !in_quote_r && !tok_r) begin
        // Home expansion, one character per cycle while the output is not stalled
        if (home_len_eff != '0) begin
          expand         = 1'b1;
          tok_nxt        = 1'b1;
          res.out_char   = home_byte;
          res.char_valid = 1'b1;
        end
      end else if (inp_r.ch == CH_SPACE) begin
        if (in_quote_r) begin
          tok_nxt        = 1'b1;
          res.out_char   = CH_SPACE;
          res.char_valid = 1'b1;
        end else if (tok_r) begin
          tok_nxt       = 1'b0;
          res.token_end = 1'b1;
        end
      end else if (inp_r.ch == CH_DQUOTE) begin
        in_quote_nxt = !in_quote_r;
        qjc_nxt      = in_quote_r;
      end else begin
        tok_nxt        = 1'b1;
        res.out_char   = inp_r.ch;
        res.char_valid = 1'b1;
      end
    end

    res.error_code = err_new;
    res.last       = !expand || (idx_r + LW'(1) == home_len_eff);
    sticky_nxt     = inp_r.mode ? ERR_NONE : err_new;
  end

  // Handshake
  logic out_free, emit, advance, in_take;
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = inp_valid_r && out_free;
  assign advance  = emit && res.last;
  assign in_stall = inp_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      in_quote_r  <= 1'b0;
      esc_r       <= 1'b0;
      tok_r       <= 1'b0;
      qjc_r       <= 1'b0;
      sticky_r    <= ERR_NONE;
    end else begin
      if (in_take) begin
        inp_valid_r <= 1'b1;
      end else if (advance) begin
        inp_valid_r <= 1'b0;
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (advance) begin
        idx_r      <= '0;
        in_quote_r <= in_quote_nxt;
        esc_r      <= esc_nxt;
        tok_r      <= tok_nxt;
        qjc_r      <= qjc_nxt;
        sticky_r   <= sticky_nxt;
      end else if (emit) begin
        idx_r <= idx_r + LW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      inp_r <= in_data;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
